>>> hdl/assert_macros.svh
// assertion macros used by the rtl core of the rms loudness detector
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, skipped while reset is low
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond))

`endif

>>> hdl/mrms_pkg.sv
// shared constants and types of the moving-window rms loudness detector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mrms_pkg;

  localparam int WINDOW_DEPTH = 8192;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int DEPTH_W      = $clog2(WINDOW_DEPTH + 1);
  localparam int SAMPLE_W     = 16;
  localparam int RMS_W        = 16;
  localparam int THR_W        = 16;
  localparam int SUM_W        = 44;
  localparam int SQ_W         = 2 * SAMPLE_W;
  localparam int LIM_W        = 2 * THR_W + DEPTH_W;
  localparam int OUT_W        = 40;

  // square root: one result bit per step, from bit 16 down to bit 0
  localparam int ROOT_STEPS   = 17;
  localparam int CNT_W        = $clog2(ROOT_STEPS);
  localparam int ROOT_W       = 2 * ROOT_STEPS + DEPTH_W;

  // register word index on the configuration port
  localparam logic [1:0] REG_STEREO    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_TOLERANCE = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(16000);
  localparam logic [THR_W-1:0] TOLERANCE_RESET = THR_W'(1000);

  localparam logic [1:0] SIDE_NONE   = 2'b00;
  localparam logic [1:0] SIDE_FIRST  = 2'b01;
  localparam logic [1:0] SIDE_SECOND = 2'b11;

  typedef struct packed {
    logic busy;
    logic done;
  } root_status_t;

endpackage

`default_nettype wire

>>> hdl/mrms_isqrt.sv
// iterative floor square root of (value / WINDOW_DEPTH), one result bit per cycle
// depends on mrms_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrms_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mrms_pkg::SUM_W-1:0]   value,
  output mrms_pkg::root_status_t       status,
  output logic [mrms_pkg::RMS_W-1:0]   root
);
  import mrms_pkg::*;

  // candidate c = r | 2^k is kept as c*c*D = t + a + b, with
  // a = r*D*2^(k+1) and b = D*2^(2k); r*r <= floor(v/D) iff r*r*D <= v
  localparam logic [ROOT_W-1:0] B_INIT = ROOT_W'(WINDOW_DEPTH) << (2 * (ROOT_STEPS - 1));

  logic [ROOT_W-1:0]     t_r;
  logic [ROOT_W-1:0]     a_r;
  logic [ROOT_W-1:0]     b_r;
  logic [ROOT_W-1:0]     s_r;
  logic [ROOT_STEPS-1:0] r_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [ROOT_W-1:0]     cand_nxt;
  logic                  take;

  assign cand_nxt = t_r + a_r + b_r;
  assign take     = (cand_nxt <= s_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_r <= '0;
      a_r <= '0;
      b_r <= B_INIT;
      s_r <= ROOT_W'(value);
      r_r <= '0;
    end else if (busy_r) begin
      r_r <= {r_r[ROOT_STEPS-2:0], take};
      if (take) begin
        t_r <= cand_nxt;
      end
      a_r <= (a_r >> 1) + (take ? b_r : '0);
      b_r <= b_r >> 2;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign root        = r_r[RMS_W-1:0];

endmodule

`default_nettype wire

>>> hdl/moving_rms_loudness_detector_core.sv
// Moving-window rms loudness detector. Each input word is one signed 16-bit sample
// (tuser selects the channel in stereo mode); each word yields one output word with
// both channels' rms levels and the loud / direction / detected flags. A word passes
// through the idle state that takes it and reads the window, the sequencing states
// (square-sum update, threshold squares, limit scaling, compare), the bit-serial
// square root (17 steps and its done strobe) and the state that loads the output
// register; a full output register holds the sequencer in that last state.
// in_tready is high only while the sequencer is idle; a new word may be taken while
// the previous result still waits.
// The sample windows are never cleared: until a channel's
// pointer wraps for the first time its old entry reads as zero.
// depends on mrms_pkg, mrms_isqrt and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module moving_rms_loudness_detector_core (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] sample
  input  logic                  in_tuser,   // [0] channel
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [mrms_pkg::OUT_W-1:0] out_tdata,
  // [15:0] rms_first, [31:16] rms_second, [32] loud, [34:33] direction,
  // [35] detected, [39:36] zero
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [3:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import mrms_pkg::*;

  `include "assert_macros.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUB   = 4'd1;
  localparam logic [3:0] S_ADD   = 4'd2;
  localparam logic [3:0] S_THR   = 4'd3;
  localparam logic [3:0] S_REL   = 4'd4;
  localparam logic [3:0] S_LIM   = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_ROOT  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_DEPTH - 1);

  // configuration registers
  logic             stereo_r;
  logic [THR_W-1:0] thr_r;
  logic [THR_W-1:0] tol_r;
  logic             cfg_wr;

  // sequencer and per-channel state
  logic [3:0]          state_r;
  logic [3:0]          state_nxt;
  logic [SAMPLE_W-1:0] sample_r;
  logic                chan_r;
  logic [ADDR_W-1:0]   ptr_first_r;
  logic [ADDR_W-1:0]   ptr_second_r;
  logic                wrap_first_r;
  logic                wrap_second_r;
  logic [SUM_W-1:0]    sum_first_r;
  logic [SUM_W-1:0]    sum_second_r;
  logic [RMS_W-1:0]    rms_first_r;
  logic [RMS_W-1:0]    rms_second_r;
  logic                loud_r;
  logic [1:0]          side_r;
  logic                seen_r;
  logic [SQ_W-1:0]     prod_r;
  logic [LIM_W-1:0]    lim_set_r;
  logic [LIM_W-1:0]    lim_rel_r;

  // sample windows
  logic [SAMPLE_W-1:0] win_first  [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] win_second [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] rd_first_r;
  logic [SAMPLE_W-1:0] rd_second_r;

  // output register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic                in_acc;
  logic                out_free;
  logic [SAMPLE_W-1:0] old_raw;
  logic [SAMPLE_W-1:0] sq_raw;
  logic [SAMPLE_W-1:0] sq_mag;
  logic [SQ_W-1:0]     sq_res;
  logic [THR_W-1:0]    rel_level;
  logic [SUM_W-1:0]    sum_sel;
  logic [SUM_W-1:0]    sum_sel_nxt;
  logic                root_start;
  root_status_t        root_st;
  logic [RMS_W-1:0]    root_val;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= 1'b0;
      thr_r    <= THRESHOLD_RESET;
      tol_r    <= TOLERANCE_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_STEREO:    stereo_r <= cfg_pwdata[0];
        REG_THRESHOLD: thr_r    <= cfg_pwdata[THR_W-1:0];
        REG_TOLERANCE: tol_r    <= cfg_pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_STEREO:    cfg_prdata = {31'b0, stereo_r};
      REG_THRESHOLD: cfg_prdata = {16'b0, thr_r};
      REG_TOLERANCE: cfg_prdata = {16'b0, tol_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // ---------------- shared squarer ----------------
  // entries past the pointer before the first wrap were never written: zero
  assign old_raw = chan_r ? (wrap_second_r ? rd_second_r : '0)
                          : (wrap_first_r  ? rd_first_r  : '0);
  assign rel_level = thr_r - tol_r;

  always_comb begin
    case (state_r)
      S_SUB:   sq_raw = old_raw;
      S_ADD:   sq_raw = sample_r;
      default: sq_raw = '0;
    endcase
  end

  // two's complement magnitude; -32768 maps to 32768, which still fits
  assign sq_mag = sq_raw[SAMPLE_W-1] ? SAMPLE_W'(-sq_raw) : sq_raw;

  always_comb begin
    case (state_r)
      S_THR:   sq_res = thr_r * thr_r;
      S_REL:   sq_res = rel_level * rel_level;
      default: sq_res = sq_mag * sq_mag;
    endcase
  end

  assign sum_sel = chan_r ? sum_second_r : sum_first_r;

  always_comb begin
    case (state_r)
      S_SUB:   sum_sel_nxt = sum_sel - SUM_W'(sq_res);
      S_ADD:   sum_sel_nxt = sum_sel + SUM_W'(sq_res);
      default: sum_sel_nxt = sum_sel;
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SUB;
      S_SUB:  state_nxt = S_ADD;
      S_ADD:  state_nxt = S_THR;
      S_THR:  state_nxt = S_REL;
      S_REL:  state_nxt = S_LIM;
      S_LIM:  state_nxt = S_CMP;
      S_CMP:  state_nxt = S_ROOT;
      S_ROOT: if (root_st.done) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign root_start = (state_r == S_CMP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ptr_first_r   <= '0;
      ptr_second_r  <= '0;
      wrap_first_r  <= 1'b0;
      wrap_second_r <= 1'b0;
      sum_first_r   <= '0;
      sum_second_r  <= '0;
      rms_first_r   <= '0;
      rms_second_r  <= '0;
      loud_r        <= 1'b0;
      side_r        <= SIDE_NONE;
      seen_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_SUB || state_r == S_ADD) begin
        if (chan_r) begin
          sum_second_r <= sum_sel_nxt;
        end else begin
          sum_first_r <= sum_sel_nxt;
        end
      end

      if (state_r == S_SUB) begin
        if (chan_r) begin
          if (ptr_second_r == LAST_ADDR) begin
            ptr_second_r  <= '0;
            wrap_second_r <= 1'b1;
          end else begin
            ptr_second_r <= ptr_second_r + 1'b1;
          end
        end else begin
          if (ptr_first_r == LAST_ADDR) begin
            ptr_first_r  <= '0;
            wrap_first_r <= 1'b1;
          end else begin
            ptr_first_r <= ptr_first_r + 1'b1;
          end
        end
      end

      // hysteresis on exact window sums: set above thr^2 * depth, clear below (thr - tol)^2 * depth
      if (state_r == S_CMP) begin
        if (!loud_r) begin
          if (LIM_W'(sum_first_r) > lim_set_r || LIM_W'(sum_second_r) > lim_set_r) begin
            loud_r <= 1'b1;
            side_r <= (sum_first_r > sum_second_r) ? SIDE_FIRST : SIDE_SECOND;
            seen_r <= 1'b1;
          end
        end else if (thr_r > tol_r) begin
          if (LIM_W'(sum_first_r) < lim_rel_r && LIM_W'(sum_second_r) < lim_rel_r) begin
            loud_r <= 1'b0;
          end
        end
      end

      if (state_r == S_ROOT && root_st.done) begin
        if (chan_r) begin
          rms_second_r <= root_val;
        end else begin
          rms_first_r <= root_val;
        end
      end

      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_tdata[SAMPLE_W-1:0];
      chan_r   <= stereo_r && in_tuser;
    end
    if (state_r == S_THR) begin
      prod_r <= sq_res;
    end
    if (state_r == S_REL) begin
      lim_set_r <= LIM_W'(prod_r) * LIM_W'(WINDOW_DEPTH);
      prod_r    <= sq_res;
    end
    if (state_r == S_LIM) begin
      lim_rel_r <= LIM_W'(prod_r) * LIM_W'(WINDOW_DEPTH);
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {4'b0, seen_r, side_r, loud_r, rms_second_r, rms_first_r};
    end
  end

  // window memories: read at accept, overwrite the oldest entry in the cycle after, in the SUB state
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_first_r  <= win_first[ptr_first_r];
      rd_second_r <= win_second[ptr_second_r];
    end
    if (state_r == S_SUB && !chan_r) begin
      win_first[ptr_first_r] <= sample_r;
    end
    if (state_r == S_SUB && chan_r) begin
      win_second[ptr_second_r] <= sample_r;
    end
  end

  mrms_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (root_start),
    .value  (sum_sel),
    .status (root_st),
    .root   (root_val)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  `ASSERT_PROP(a_loud_marks_seen, clk, rst_n, loud_r |-> (seen_r && side_r != SIDE_NONE))
  `ASSERT_PROP(a_seen_sticky, clk, rst_n, seen_r |=> seen_r)
  `ASSERT_NEVER(a_root_done_in_root, clk, rst_n, root_st.done && state_r != S_ROOT)

endmodule

`default_nettype wire
